### rtl/core/rgbed_pkg.sv
package rgbed_pkg;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  localparam int CfgWidthBits  = 11;
  localparam int CfgHeightBits = 13;
  localparam int MaxHeight     = 4096;
  localparam int RowBits       = 12;
  localparam int LevelBits     = 2;
  localparam int Channels      = 3;

  localparam logic [CfgWidthBits-1:0]  WidthReset  = 11'd320;
  localparam logic [CfgHeightBits-1:0] HeightReset = 13'd200;

  localparam int WeightRight      = 7;
  localparam int WeightBelow      = 5;
  localparam int WeightBelowLeft  = 3;
  localparam int WeightBelowRight = 1;
  localparam int WeightShift      = 4;

  typedef logic [LevelBits-1:0] level_t;

endpackage

### rtl/core/rgb_error_diffusion_dither.sv
// Floyd-Steinberg error diffusion for RGB pixels in raster order, each channel quantized on
// its own to four levels and returned as a 6-bit index (red in bits 5:4, green 3:2, blue 1:0),
// with tlast marking the final pixel of a frame. The block takes one pixel per clock unless
// the line store is being cleared or the output stalls; each result passes through the s1
// and output registers. The rate is set by the error line store: one read and one write
// per pixel, the second write at a row end deferred to a free write slot. After reset the
// line store is cleared one entry per cycle, MAX_WIDTH entries (1024 by default), and
// s_axis_tready stays low until it is done. Image width and height are set over the APB
// port at byte addresses 0 and 4 and must be changed only while no pixel is in flight.
module rgb_error_diffusion_dither #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // color_index [5:0], zero [7:6]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > rgbed_pkg::CfgWidthBits) ? AW + 1 : rgbed_pkg::CfgWidthBits;
  localparam int HW = rgbed_pkg::CfgHeightBits;
  localparam int RW = rgbed_pkg::RowBits;
  localparam int EW = FRAC_BITS + 8;
  localparam int VW = FRAC_BITS + 11;
  localparam int QS = FRAC_BITS + 6;
  localparam int MW = rgbed_pkg::Channels * EW;
  localparam int NC = rgbed_pkg::Channels;

  function automatic logic signed [EW-1:0] weigh(input logic signed [EW-1:0] e,
                                                 input logic [2:0] k);
    logic signed [EW+2:0] ext;
    logic [EW+2:0] mag;
    logic [EW+2:0] prod;
    logic [EW+2:0] res;
    ext  = (EW+3)'(e);
    mag  = ext[EW+2] ? unsigned'(-ext) : unsigned'(ext);
    prod = mag * (EW+3)'(k);
    res  = prod >> rgbed_pkg::WeightShift;
    return ext[EW+2] ? EW'(-res) : EW'(res);
  endfunction

  logic [rgbed_pkg::CfgWidthBits-1:0] cfg_width;
  logic [HW-1:0] cfg_height;

  logic clr_busy;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;

  logic s1_v;
  logic [7:0] s1_pix [NC];
  logic [AW-1:0] s1_x;
  logic s1_top;
  logic s1_row_end;
  logic s1_frame_end;
  logic s1_has_below;
  logic fwd_hit;
  logic [MW-1:0] fwd_data;

  logic signed [EW-1:0] rc [NC];
  logic signed [EW-1:0] bp0 [NC];
  logic signed [EW-1:0] bp1 [NC];

  logic pend_v;
  logic [AW-1:0] pend_addr;
  logic [MW-1:0] pend_data;

  logic out_v;
  logic [5:0] out_idx;
  logic out_last;

  logic in_fire;
  logic s1_fire;
  logic cfg_wr;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW-1:0] x_p1;
  logic [HW-1:0] y_p1;
  logic row_end_in;
  logic has_below_in;
  logic frame_end_in;

  logic [MW-1:0] ram_rdata;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;

  logic wa_en;
  logic wb_en;
  logic pend_load;
  logic [AW-1:0] wa_addr;
  logic [MW-1:0] wa_data;
  logic [MW-1:0] wb_data;
  logic fwd_hit_next;
  logic [MW-1:0] fwd_data_next;

  logic signed [VW-1:0] v [NC];
  logic signed [VW-1:0] q [NC];
  logic signed [VW-1:0] e_full [NC];
  logic signed [EW-1:0] e [NC];
  logic signed [EW-1:0] above [NC];
  logic signed [EW-1:0] rc_next [NC];
  logic signed [EW-1:0] bp0_next [NC];
  logic signed [EW-1:0] bp1_next [NC];
  rgbed_pkg::level_t lvl [NC];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (rgbed_pkg::reg_index_t'(paddr[2]))
      rgbed_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_width);
      rgbed_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_height);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= rgbed_pkg::WidthReset;
      cfg_height <= rgbed_pkg::HeightReset;
    end else if (cfg_wr) begin
      unique case (rgbed_pkg::reg_index_t'(paddr[2]))
        rgbed_pkg::REG_IMAGE_WIDTH:  cfg_width <= pwdata[rgbed_pkg::CfgWidthBits-1:0];
        rgbed_pkg::REG_IMAGE_HEIGHT: cfg_height <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  // Position of the pixel offered on the input.
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WW'(1);
    end else if (WW'(cfg_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = HW'(1);
    end else if (cfg_height > HW'(rgbed_pkg::MaxHeight)) begin
      h_eff = HW'(rgbed_pkg::MaxHeight);
    end else begin
      h_eff = cfg_height;
    end
    x_p1         = WW'(col_cnt) + WW'(1);
    y_p1         = HW'(row_cnt) + HW'(1);
    row_end_in   = x_p1 >= w_eff;
    has_below_in = y_p1 < h_eff;
    frame_end_in = row_end_in && !has_below_in;
  end

  assign s1_fire       = s1_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !clr_busy && (!s1_v || s1_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_fire) begin
      if (row_end_in) begin
        col_cnt <= '0;
        row_cnt <= frame_end_in ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_WIDTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Per-channel diffusion and quantization.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (s1_top) begin
        above[c] = '0;
      end else if (fwd_hit) begin
        above[c] = fwd_data[c*EW +: EW];
      end else begin
        above[c] = ram_rdata[c*EW +: EW];
      end
      v[c] = (VW'(s1_pix[c]) <<< FRAC_BITS) + VW'(rc[c]) + VW'(above[c]);
      if (v[c][VW-1]) begin
        q[c] = -((-v[c] + (VW'(32) <<< FRAC_BITS)) >>> QS);
      end else begin
        q[c] = (v[c] + (VW'(32) <<< FRAC_BITS)) >>> QS;
      end
      e_full[c] = v[c] - (q[c] <<< QS);
      e[c]      = EW'(e_full[c]);
      if (q[c][VW-1]) begin
        lvl[c] = '0;
      end else if (|q[c][VW-2:rgbed_pkg::LevelBits]) begin
        lvl[c] = '1;
      end else begin
        lvl[c] = q[c][rgbed_pkg::LevelBits-1:0];
      end
      rc_next[c]  = s1_row_end ? '0 : weigh(e[c], 3'(rgbed_pkg::WeightRight));
      bp0_next[c] = bp1[c] + weigh(e[c], 3'(rgbed_pkg::WeightBelow));
      bp1_next[c] = s1_row_end ? '0 : weigh(e[c], 3'(rgbed_pkg::WeightBelowRight));
      wa_data[c*EW +: EW] = bp0[c] + weigh(e[c], 3'(rgbed_pkg::WeightBelowLeft));
      wb_data[c*EW +: EW] = bp0_next[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        rc[c]  <= '0;
        bp0[c] <= '0;
        bp1[c] <= '0;
      end
    end else if (s1_fire) begin
      for (int c = 0; c < NC; c++) begin
        rc[c] <= rc_next[c];
        if (s1_row_end) begin
          bp0[c] <= '0;
          bp1[c] <= '0;
        end else if (s1_has_below) begin
          bp0[c] <= bp0_next[c];
          bp1[c] <= bp1_next[c];
        end
      end
    end
  end

  // Line store writes. At the end of a row with a row below, two entries change (one in a
  // one-pixel row); the second waits in the pending register until a free write slot.
  assign wa_en     = s1_fire && s1_has_below && (s1_x != '0);
  assign wb_en     = s1_fire && s1_has_below && s1_row_end;
  assign wa_addr   = s1_x - AW'(1);
  assign pend_load = wa_en && wb_en;

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = pend_addr;
    ram_wdata = pend_data;
    priority if (clr_busy) begin
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (wa_en) begin
      ram_waddr = wa_addr;
      ram_wdata = wa_data;
    end else if (wb_en) begin
      ram_waddr = s1_x;
      ram_wdata = wb_data;
    end else if (pend_v) begin
      ram_waddr = pend_addr;
      ram_wdata = pend_data;
    end else begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (pend_load) begin
      pend_v <= 1'b1;
    end else if (!clr_busy && !wa_en && !wb_en) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_addr <= s1_x;
      pend_data <= wb_data;
    end
  end

  // Forwarding of writes that land at the same edge as the read, or that still wait.
  always_comb begin
    fwd_hit_next  = 1'b1;
    fwd_data_next = pend_data;
    priority if (wa_en && (wa_addr == col_cnt)) begin
      fwd_data_next = wa_data;
    end else if (wb_en && (s1_x == col_cnt)) begin
      fwd_data_next = wb_data;
    end else if (pend_v && (pend_addr == col_cnt)) begin
      fwd_data_next = pend_data;
    end else begin
      fwd_hit_next = 1'b0;
    end
  end

  rgbed_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_fire),
    .raddr(col_cnt),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_fire) begin
      s1_v <= 1'b1;
    end else if (s1_fire) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix[0]    <= s_axis_tdata[7:0];
      s1_pix[1]    <= s_axis_tdata[15:8];
      s1_pix[2]    <= s_axis_tdata[23:16];
      s1_x         <= col_cnt;
      s1_top       <= (row_cnt == '0);
      s1_row_end   <= row_end_in;
      s1_frame_end <= frame_end_in;
      s1_has_below <= has_below_in;
      fwd_hit      <= fwd_hit_next;
      fwd_data     <= fwd_data_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s1_fire) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_idx  <= {lvl[0], lvl[1], lvl[2]};
      out_last <= s1_frame_end;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = 8'(out_idx);
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_axis_tready)
    else $error("input accepted during line store clear");

  a_pending_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    pend_load |-> !pend_v)
    else $error("deferred line store write overwritten before it was flushed");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && frame_end_in) |=> (col_cnt == '0) && (row_cnt == '0))
    else $error("position counters did not wrap at frame end");

  a_output_follows_stage: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_axis_tvalid)
    else $error("computed pixel did not reach the output register");
`endif

endmodule

### rtl/core/rgbed_ram.sv
module rgbed_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### verif/rgb_error_diffusion_dither_tb.sv
module rgb_error_diffusion_dither_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH    = 1024;
  localparam int FRAC_BITS    = 8;
  localparam int QuantStep    = 64 << FRAC_BITS;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [5:0] color;
    logic       frame_end;
  } dither_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // color_index [5:0], zero [7:6]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_error_diffusion_dither u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk = ~clk;

  dither_out_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;

  logic [rgbed_pkg::CfgWidthBits-1:0]  cfg_width  = rgbed_pkg::WidthReset;
  logic [rgbed_pkg::CfgHeightBits-1:0] cfg_height = rgbed_pkg::HeightReset;
  int row_err[MAX_WIDTH][rgbed_pkg::Channels];
  int right_err[rgbed_pkg::Channels];
  int below_err[2][rgbed_pkg::Channels];
  int col_pos = 0;
  int row_pos = 0;

  function automatic int share(int e, int k);
    if (e >= 0) begin
      return (e * k) / (1 << rgbed_pkg::WeightShift);
    end
    return -(((-e) * k) / (1 << rgbed_pkg::WeightShift));
  endfunction

  function automatic int round_to_step(int v);
    if (v >= 0) begin
      return (v + QuantStep / 2) / QuantStep;
    end
    return -(((-v) + QuantStep / 2) / QuantStep);
  endfunction

  function automatic dither_out_t dither_pixel(logic [23:0] rgb);
    int w, h, x, y, v, q, e, lvl, pa, pb, above;
    logic row_end, frame_end, has_below;
    dither_out_t res;
    w = cfg_width;
    h = cfg_height;
    if (w < 1) begin
      w = 1;
    end
    if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    if (h < 1) begin
      h = 1;
    end
    if (h > rgbed_pkg::MaxHeight) begin
      h = rgbed_pkg::MaxHeight;
    end
    x = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    y = row_pos;
    row_end = (x + 1 >= w);
    frame_end = row_end && (y + 1 >= h);
    has_below = (y + 1 < h);
    res.color = '0;
    for (int c = 0; c < rgbed_pkg::Channels; c++) begin
      above = (y == 0) ? 0 : row_err[x][c];
      v = int'(rgb[8*c +: 8]) * (1 << FRAC_BITS) + right_err[c] + above;
      q = round_to_step(v);
      e = v - q * QuantStep;
      lvl = (q < 0) ? 0 : (q > 3) ? 3 : q;
      res.color = {res.color[3:0], 2'(lvl)};
      right_err[c] = row_end ? 0 : share(e, rgbed_pkg::WeightRight);
      if (has_below) begin
        pa = below_err[0][c];
        pb = below_err[1][c];
        if (x > 0) begin
          row_err[x-1][c] = pa + share(e, rgbed_pkg::WeightBelowLeft);
        end
        below_err[0][c] = pb + share(e, rgbed_pkg::WeightBelow);
        below_err[1][c] = row_end ? 0 : share(e, rgbed_pkg::WeightBelowRight);
        if (row_end) begin
          row_err[x][c] = below_err[0][c];
        end
      end
    end
    if (row_end) begin
      right_err = '{default: 0};
      below_err = '{default: 0};
      col_pos = 0;
      row_pos = frame_end ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    res.frame_end = frame_end;
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stalls_on && stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dither_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected transfer, expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== {2'b00, want.color}) begin
          errors = errors + 1;
          $display("%0t: color_index mismatch, expected %h, actual %h",
                   $time, {2'b00, want.color}, m_axis_tdata);
        end
        if (m_axis_tlast !== want.frame_end) begin
          errors = errors + 1;
          $display("%0t: tlast mismatch, expected %b, actual %b",
                   $time, want.frame_end, m_axis_tlast);
        end
      end
    end
  end

  task automatic write_reg(rgbed_pkg::reg_index_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == rgbed_pkg::REG_IMAGE_WIDTH) begin
      cfg_width = value[rgbed_pkg::CfgWidthBits-1:0];
    end else begin
      cfg_height = value[rgbed_pkg::CfgHeightBits-1:0];
    end
  endtask

  task automatic set_frame(int w, int h);
    write_reg(rgbed_pkg::REG_IMAGE_WIDTH, 32'(w));
    write_reg(rgbed_pkg::REG_IMAGE_HEIGHT, 32'(h));
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(dither_pixel({b, g, r}));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(32 * $urandom_range(1, 7) - $urandom_range(0, 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pixel();
    send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic test_reset_defaults();
    repeat (5) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_directed_corners();
    set_frame(1, 1);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd32, 8'd31, 8'd96);
    send_pixel(8'd95, 8'd160, 8'd159);
    send_pixel(8'd224, 8'd223, 8'd128);
    wait_drained();
    set_frame(2, 2);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd127, 8'd128, 8'd1);
    send_pixel(8'd254, 8'd64, 8'd63);
    wait_drained();
    set_frame(0, 0);
    repeat (2) send_random_pixel();
    wait_drained();
    set_frame(2047, 8191);
    repeat (3) send_random_pixel();
    wait_drained();
    // The position is past the new row end, so the next pixel closes the row.
    write_reg(rgbed_pkg::REG_IMAGE_WIDTH, 32'd2);
    repeat (3) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_full_width_rows();
    set_frame(MAX_WIDTH, 2);
    repeat (MAX_WIDTH + 26) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_random_frames();
    int n, w, h;
    for (int p = 0; p < 10; p++) begin
      if ($urandom_range(0, 5) == 0) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
      end else if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(33, 200);
      end else begin
        w = $urandom_range(1, 32);
      end
      if ($urandom_range(0, 7) == 0) begin
        h = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
      end else begin
        h = $urandom_range(1, 8);
      end
      case ($urandom_range(0, 3))
        0: write_reg(rgbed_pkg::REG_IMAGE_WIDTH, 32'(w));
        1: write_reg(rgbed_pkg::REG_IMAGE_HEIGHT, 32'(h));
        default: set_frame(w, h);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(15, 35);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && p % 3 == 0) begin
          wait_drained();
        end
        send_random_pixel();
      end
      wait_drained();
    end
  endtask

  task automatic test_streaming_no_idle();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_frame($urandom_range(1, 16), $urandom_range(1, 4));
    repeat (100) send_random_pixel();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_corners();
    test_full_width_rows();
    test_random_frames();
    test_streaming_no_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rgbed_pkg.sv
rtl/core/rgbed_ram.sv
rtl/core/rgb_error_diffusion_dither.sv
verif/rgb_error_diffusion_dither_tb.sv
